FILE: src/gem_pkg.sv
// shared types and constants for the gradient energy map
package gem_pkg;

    localparam int CH_W         = 8;
    localparam int WIDTH_REG_W  = 12;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 13;
    localparam int ROW_W        = 13;
    localparam int COL_W        = 12;
    localparam int ENERGY_W     = 25;
    localparam int OUT_ROW_W    = 12;
    localparam int OUT_COL_W    = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [ENERGY_W-1:0] BORDER_HALF = 25'd19999998;

    // position and border flags of one pixel as it moves down the chain
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             has_above;
        logic             interior;
        logic             last_row;
        logic             last_col;
    } t_meta;

endpackage

FILE: src/gem_pix_if.sv
// pixel input channel
interface gem_pix_if;
    logic                     valid;
    logic                     ready;
    logic [gem_pkg::CH_W-1:0] red;
    logic [gem_pkg::CH_W-1:0] green;
    logic [gem_pkg::CH_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

FILE: src/gem_energy_if.sv
// energy result channel
interface gem_energy_if;
    logic                          valid;
    logic                          ready;
    logic [gem_pkg::ENERGY_W-1:0]  energy_half;
    logic [gem_pkg::OUT_ROW_W-1:0] row;
    logic [gem_pkg::OUT_COL_W-1:0] col;
    logic                          last_of_image;

    modport source (output valid, output energy_half, output row, output col,
                    output last_of_image, input ready);
    modport sink   (input valid, input energy_half, input row, input col,
                    input last_of_image, output ready);
endinterface

FILE: src/gradient_energy_map_core.sv
// top level: raster pixel stream in, gradient energy map out
//
// Pixels enter on i_pix (valid/ready, one word per pixel in raster order) and
// energy words leave on o_nrg with their row, column and an end-of-image flag.
// Image size is set by writing register 0 (width) or 1 (height) through
// i_cfg_we/i_cfg_idx/i_cfg_data while the block is idle; a write restarts
// the image at row 0, column 0.
// The pixel at (r,c) releases the energy of (r-1,c), which reaches o_nrg
// through the read stage, whose line store read shares the taking edge, then
// the three channel cells and the output register.
// Throughput is one pixel per cycle while o_nrg takes words; in the last
// row each pixel below row 0 gives two words, and the output register keeps
// that pixel until both words are taken.
// The row above lives in a one-port-write, one-port-read ram of MAX_WIDTH
// words; column 0 of it is also kept in a register for the second read.
// Reset sets the size to 640 x 480 and the position to row 0, column 0; the
// line store is not cleared: row 0 always fills it before its data is used.
// A stall on o_nrg backs up through the elastic cell chain; up to five
// pixels stay in flight and i_pix.ready drops only once every stage is full.
module gradient_energy_map_core #(
    parameter int MAX_WIDTH    = 2048,
    parameter int MAX_HEIGHT   = 4096,
    parameter int CHANNEL_BITS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [gem_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [gem_pkg::CFG_DATA_W-1:0] i_cfg_data,
    gem_pix_if.sink                      i_pix,
    gem_energy_if.source                 o_nrg
);
    import gem_pkg::*;

    localparam int CB = CHANNEL_BITS;
    localparam int PW = 3 * CB;
    localparam int SW = CB + 3;
    localparam int AW = $clog2(MAX_WIDTH);

    // configuration and position
    logic [WIDTH_REG_W-1:0]  r_img_w;
    logic [HEIGHT_REG_W-1:0] r_img_h;
    logic [COL_W-1:0]        w_eff;
    logic [ROW_W-1:0]        h_eff;
    logic [COL_W-1:0]        r_col;
    logic [ROW_W-1:0]        r_row;

    always_comb begin
        if (r_img_w == '0) begin
            w_eff = COL_W'(1);
        end else if (r_img_w > MAX_WIDTH) begin
            w_eff = COL_W'(MAX_WIDTH);
        end else begin
            w_eff = r_img_w;
        end
        if (r_img_h == '0) begin
            h_eff = ROW_W'(1);
        end else if (r_img_h > MAX_HEIGHT) begin
            h_eff = ROW_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_img_h;
        end
    end

    logic          accept;
    logic          s1_ready;
    logic [PW-1:0] pix;
    t_meta         in_meta;

    assign i_pix.ready = s1_ready;
    assign accept      = i_pix.valid && s1_ready;
    assign pix         = {CB'(i_pix.blue), CB'(i_pix.green), CB'(i_pix.red)};

    always_comb begin
        in_meta.row       = r_row;
        in_meta.col       = r_col;
        in_meta.has_above = (r_row != '0);
        in_meta.interior  = (r_col != w_eff - COL_W'(1));
        in_meta.last_row  = (r_row == h_eff - ROW_W'(1));
        in_meta.last_col  = (r_col == w_eff - COL_W'(1));
    end

    logic [PW-1:0] r_held;
    logic [PW-1:0] ram_rdata;
    logic          s1_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= WIDTH_REG_W'(640);
            r_img_h <= HEIGHT_REG_W'(480);
            r_col   <= '0;
            r_row   <= '0;
            r_held  <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_IMAGE_WIDTH) begin
                r_img_w <= i_cfg_data[WIDTH_REG_W-1:0];
            end else begin
                r_img_h <= i_cfg_data[HEIGHT_REG_W-1:0];
            end
            r_col  <= '0;
            r_row  <= '0;
            r_held <= '0;
        end else begin
            if (accept) begin
                if (in_meta.last_col) begin
                    r_col <= '0;
                    r_row <= in_meta.last_row ? '0 : r_row + ROW_W'(1);
                end else begin
                    r_col <= r_col + COL_W'(1);
                end
            end
            // above-right of this pixel is the above of the next one
            if (s1_move) begin
                r_held <= ram_rdata;
            end
        end
    end

    // line store of the previous row
    gem_ram #(
        .W     (PW),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (AW'(r_col)),
        .i_wdata (pix),
        .i_re    (accept),
        .i_raddr (AW'(r_col + COL_W'(1))),
        .o_rdata (ram_rdata)
    );

    // column 0 copy, read in the same cycle as column 1
    logic [PW-1:0] r_col0;

    always_ff @(posedge i_clk) begin
        if (accept && r_col == '0) begin
            r_col0 <= pix;
        end
    end

    // read stage, aligned with the ram data
    logic          r_s1_valid;
    logic [PW-1:0] r_s1_pix;
    logic [PW-1:0] r_s1_above0;
    t_meta         r_s1_meta;

    logic          c_valid [4];
    logic          c_ready [4];
    logic [SW-1:0] c_sum   [4];
    t_meta         c_meta  [4];
    logic [PW-1:0] c_above [3];
    logic [PW-1:0] c_right [3];
    logic [PW-1:0] c_below [3];

    assign s1_ready = !r_s1_valid || c_ready[0];
    assign s1_move  = r_s1_valid && c_ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix    <= pix;
            r_s1_above0 <= r_col0;
            r_s1_meta   <= in_meta;
        end
    end

    assign c_valid[0] = r_s1_valid;
    assign c_above[0] = (r_s1_meta.col == '0) ? r_s1_above0 : r_held;
    assign c_right[0] = ram_rdata;
    assign c_below[0] = r_s1_pix;
    assign c_sum[0]   = '0;
    assign c_meta[0]  = r_s1_meta;

    for (genvar k = 0; k < 3; k++) begin : g_cell
        if (k < 2) begin : g_mid
            gem_cell #(
                .CB (CB),
                .K  (k)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (c_valid[k]),
                .o_ready (c_ready[k]),
                .i_above (c_above[k]),
                .i_right (c_right[k]),
                .i_below (c_below[k]),
                .i_sum   (c_sum[k]),
                .i_meta  (c_meta[k]),
                .o_valid (c_valid[k+1]),
                .i_ready (c_ready[k+1]),
                .o_above (c_above[k+1]),
                .o_right (c_right[k+1]),
                .o_below (c_below[k+1]),
                .o_sum   (c_sum[k+1]),
                .o_meta  (c_meta[k+1])
            );
        end else begin : g_end
            gem_cell #(
                .CB (CB),
                .K  (k)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (c_valid[k]),
                .o_ready (c_ready[k]),
                .i_above (c_above[k]),
                .i_right (c_right[k]),
                .i_below (c_below[k]),
                .i_sum   (c_sum[k]),
                .i_meta  (c_meta[k]),
                .o_valid (c_valid[k+1]),
                .i_ready (c_ready[k+1]),
                .o_above (),
                .o_right (),
                .o_below (),
                .o_sum   (c_sum[k+1]),
                .o_meta  (c_meta[k+1])
            );
        end
    end

    // output register: the row-above energy first, then the own border word
    logic          r_out_valid;
    logic          r_first;
    logic [SW-1:0] r_out_sum;
    t_meta         r_out_meta;
    logic          pop;
    logic          hold;

    assign pop        = r_out_valid && o_nrg.ready;
    assign hold       = r_first && r_out_meta.last_row;
    assign c_ready[3] = !r_out_valid || (pop && !hold);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_first     <= 1'b0;
        end else if (c_ready[3]) begin
            r_out_valid <= c_valid[3] && (c_meta[3].has_above || c_meta[3].last_row);
            r_first     <= c_meta[3].has_above;
        end else if (pop) begin
            r_first <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_ready[3] && c_valid[3]) begin
            r_out_sum  <= c_sum[3];
            r_out_meta <= c_meta[3];
        end
    end

    logic [ROW_W-1:0] row_above;

    assign row_above = r_out_meta.row - ROW_W'(1);

    always_comb begin
        o_nrg.valid = r_out_valid;
        if (r_first) begin
            o_nrg.energy_half   = r_out_meta.interior ? ENERGY_W'(r_out_sum) : BORDER_HALF;
            o_nrg.row           = OUT_ROW_W'(row_above);
            o_nrg.last_of_image = 1'b0;
        end else begin
            o_nrg.energy_half   = BORDER_HALF;
            o_nrg.row           = OUT_ROW_W'(r_out_meta.row);
            o_nrg.last_of_image = r_out_meta.last_col;
        end
        o_nrg.col = OUT_COL_W'(r_out_meta.col);
    end

endmodule

FILE: src/gem_ram.sv
// generic single write, single read ram with registered read data
module gem_ram #(
    parameter int W     = 24,
    parameter int DEPTH = 2048,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/gem_cell.sv
// one channel cell: adds its channel's two absolute differences to the running sum
module gem_cell #(
    parameter int CB = 8,
    parameter int K  = 0,
    localparam int PW = 3 * CB,
    localparam int SW = CB + 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [PW-1:0]        i_above,
    input  logic [PW-1:0]        i_right,
    input  logic [PW-1:0]        i_below,
    input  logic [SW-1:0]        i_sum,
    input  gem_pkg::t_meta       i_meta,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [PW-1:0]        o_above,
    output logic [PW-1:0]        o_right,
    output logic [PW-1:0]        o_below,
    output logic [SW-1:0]        o_sum,
    output gem_pkg::t_meta       o_meta
);
    import gem_pkg::*;

    logic          r_valid;
    logic [PW-1:0] r_above;
    logic [PW-1:0] r_right;
    logic [PW-1:0] r_below;
    logic [SW-1:0] r_sum;
    t_meta         r_meta;

    logic [CB-1:0] a_ch;
    logic [CB-1:0] r_ch;
    logic [CB-1:0] b_ch;
    logic [CB-1:0] d_right;
    logic [CB-1:0] d_below;
    logic [SW-1:0] n_sum;

    always_comb begin
        a_ch    = i_above[K*CB +: CB];
        r_ch    = i_right[K*CB +: CB];
        b_ch    = i_below[K*CB +: CB];
        d_right = (a_ch > r_ch) ? (a_ch - r_ch) : (r_ch - a_ch);
        d_below = (a_ch > b_ch) ? (a_ch - b_ch) : (b_ch - a_ch);
        n_sum   = i_sum + SW'(d_right) + SW'(d_below);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_above <= i_above;
            r_right <= i_right;
            r_below <= i_below;
            r_sum   <= n_sum;
            r_meta  <= i_meta;
        end
    end

    assign o_valid = r_valid;
    assign o_above = r_above;
    assign o_right = r_right;
    assign o_below = r_below;
    assign o_sum   = r_sum;
    assign o_meta  = r_meta;

endmodule

FILE: verif/tb.sv
// self-checking testbench for the gradient energy map core
`timescale 1ns / 100ps

module tb;
    import gem_pkg::*;

    localparam int IMG_MAX_W   = 2048;
    localparam int IMG_MAX_H   = 4096;
    localparam int WIDE_W      = 512;
    localparam int RAND_PIXELS = 600;
    localparam int SETTLE      = 20;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_pix;

    typedef struct packed {
        logic [ENERGY_W-1:0]  energy_half;
        logic [OUT_ROW_W-1:0] row;
        logic [OUT_COL_W-1:0] col;
        logic                 last_of_image;
    } t_energy_word;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    gem_pix_if    pix_ch ();
    gem_energy_if nrg_ch ();

    gradient_energy_map_core #(
        .MAX_WIDTH    (IMG_MAX_W),
        .MAX_HEIGHT   (IMG_MAX_H),
        .CHANNEL_BITS (CH_W)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_pix      (pix_ch),
        .o_nrg      (nrg_ch)
    );

    // energy map model state
    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    t_pix                    above_line [IMG_MAX_W];
    t_pix                    held_px;
    int unsigned             row_pos;
    int unsigned             col_pos;

    t_pix         pixel_q [$];
    t_energy_word energy_q [$];
    t_pix         next_px;
    t_energy_word got_word;
    t_energy_word want_word;

    int unsigned pushed_cnt;
    int unsigned accepted_cnt;
    int unsigned err_cnt;
    int unsigned cycle_cnt;
    int unsigned src_idle_pct;
    int unsigned snk_idle_pct;
    int unsigned hold_left;
    logic        hold_kick;

    function automatic int unsigned absdiff(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b);
        return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
    endfunction

    function automatic int unsigned chan_dist(input t_pix a, input t_pix b);
        return absdiff(a.red, b.red) + absdiff(a.green, b.green) + absdiff(a.blue, b.blue);
    endfunction

    // works out the energy words released by one accepted pixel
    function automatic void predict_pixel(input t_pix px);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        int unsigned e;
        t_pix        above;
        w = width_reg;
        h = height_reg;
        if (w == 0) w = 1;
        if (w > IMG_MAX_W) w = IMG_MAX_W;
        if (h == 0) h = 1;
        if (h > IMG_MAX_H) h = IMG_MAX_H;
        r = row_pos;
        c = col_pos;
        if (c >= w) c = w - 1;
        if (r >= h) r = h - 1;
        if (r >= 1) begin
            above = (c == 0) ? above_line[0] : held_px;
            if (c + 1 < w) begin
                held_px = above_line[c + 1];
                e = chan_dist(above, held_px) + chan_dist(above, px);
            end else begin
                e = BORDER_HALF;
            end
            energy_q.push_back('{ENERGY_W'(e), OUT_ROW_W'(r - 1), OUT_COL_W'(c), 1'b0});
        end
        above_line[c] = px;
        // last row also reports its own border word
        if (r == h - 1) begin
            energy_q.push_back('{BORDER_HALF, OUT_ROW_W'(r), OUT_COL_W'(c), c == w - 1});
        end
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        col_pos = c;
        row_pos = r;
    endfunction

    function automatic t_pix random_pixel();
        t_pix px;
        px = t_pix'(24'($urandom()));
        if ($urandom_range(7) == 0) px.red   = $urandom_range(1) ? '1 : '0;
        if ($urandom_range(7) == 0) px.green = $urandom_range(1) ? '1 : '0;
        if ($urandom_range(7) == 0) px.blue  = $urandom_range(1) ? '1 : '0;
        return px;
    endfunction

    // any register write restarts the image
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= CFG_DATA_W'(val);
        if (idx == CFG_IMAGE_WIDTH) width_reg = WIDTH_REG_W'(val);
        else height_reg = HEIGHT_REG_W'(val);
        row_pos = 0;
        col_pos = 0;
        held_px = '0;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_random(input int unsigned n);
        repeat (n) begin
            pixel_q.push_back(random_pixel());
            pushed_cnt++;
        end
    endtask

    task automatic wait_idle();
        while (accepted_cnt != pushed_cnt) @(posedge clk);
        while (energy_q.size() != 0) @(posedge clk);
        // row 0 pixels give no word and may still be in flight
        repeat (SETTLE) @(posedge clk);
    endtask

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // pixel driver
    always @(posedge clk) begin
        if (!rst_n) begin
            pix_ch.valid <= 1'b0;
        end else begin
            if (pix_ch.valid && pix_ch.ready) begin
                predict_pixel({pix_ch.red, pix_ch.green, pix_ch.blue});
                accepted_cnt++;
            end
            if (!pix_ch.valid || pix_ch.ready) begin
                if (pixel_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    next_px = pixel_q.pop_front();
                    pix_ch.valid <= 1'b1;
                    pix_ch.red   <= next_px.red;
                    pix_ch.green <= next_px.green;
                    pix_ch.blue  <= next_px.blue;
                end else begin
                    pix_ch.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
        end else if (hold_kick) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // energy monitor
    always @(posedge clk) begin
        if (!rst_n) begin
            nrg_ch.ready <= 1'b0;
        end else begin
            if (nrg_ch.valid && nrg_ch.ready) begin
                got_word = '{nrg_ch.energy_half, nrg_ch.row, nrg_ch.col, nrg_ch.last_of_image};
                if (energy_q.size() == 0) begin
                    $error("unexpected energy word at row %0d col %0d", got_word.row, got_word.col);
                    err_cnt++;
                end else begin
                    want_word = energy_q.pop_front();
                    if (got_word.energy_half !== want_word.energy_half) begin
                        $error("energy_half: expected %0d, got %0d",
                               want_word.energy_half, got_word.energy_half);
                        err_cnt++;
                    end
                    if (got_word.row !== want_word.row) begin
                        $error("row: expected %0d, got %0d", want_word.row, got_word.row);
                        err_cnt++;
                    end
                    if (got_word.col !== want_word.col) begin
                        $error("col: expected %0d, got %0d", want_word.col, got_word.col);
                        err_cnt++;
                    end
                    if (got_word.last_of_image !== want_word.last_of_image) begin
                        $error("last_of_image: expected %0d, got %0d",
                               want_word.last_of_image, got_word.last_of_image);
                        err_cnt++;
                    end
                end
            end
            nrg_ch.ready <= (hold_left == 0) && !hold_kick &&
                            ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial begin
        logic [23:0] corner_px [13];
        int unsigned w;
        int unsigned h;
        int unsigned n;
        int unsigned rand_sent;
        bit          held_once;

        corner_px = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
                      24'hFFFFFF, 24'h000000, 24'hFF00FF, 24'h00FFFF, 24'h123456,
                      24'hFFFFFF, 24'h000000, 24'h80FF01};
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = CFG_IMAGE_WIDTH;
        cfg_data     = '0;
        pix_ch.valid = 1'b0;
        pix_ch.red   = '0;
        pix_ch.green = '0;
        pix_ch.blue  = '0;
        nrg_ch.ready = 1'b0;
        hold_kick    = 1'b0;
        cycle_cnt    = 0;
        err_cnt      = 0;
        pushed_cnt   = 0;
        accepted_cnt = 0;
        src_idle_pct = 22;
        snk_idle_pct = 65;
        width_reg    = 640;
        height_reg   = 480;
        row_pos      = 0;
        col_pos      = 0;
        held_px      = '0;
        foreach (above_line[i]) above_line[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // 3x3 image of extreme pixels, then a partial second image
        write_reg(CFG_IMAGE_WIDTH, 3);
        write_reg(CFG_IMAGE_HEIGHT, 3);
        foreach (corner_px[i]) begin
            pixel_q.push_back(t_pix'(corner_px[i]));
            pushed_cnt++;
        end
        wait_idle();

        // zero size acts as one pixel
        write_reg(CFG_IMAGE_WIDTH, 0);
        write_reg(CFG_IMAGE_HEIGHT, 0);
        queue_random(2);
        wait_idle();

        // oversize in both registers, first row only
        write_reg(CFG_IMAGE_HEIGHT, 8191);
        write_reg(CFG_IMAGE_WIDTH, 4095);
        queue_random(3);
        wait_idle();

        // one column, tallest image
        write_reg(CFG_IMAGE_WIDTH, 1);
        queue_random(6);
        wait_idle();

        // wide one-row image, wrapping into the next image
        write_reg(CFG_IMAGE_WIDTH, WIDE_W);
        write_reg(CFG_IMAGE_HEIGHT, 1);
        queue_random(WIDE_W + 3);
        wait_idle();

        rand_sent = 0;
        held_once = 1'b0;
        while (rand_sent < RAND_PIXELS) begin
            if (rand_sent < RAND_PIXELS / 3) begin
                src_idle_pct = 22;
                snk_idle_pct = 65;
            end else if (rand_sent < 2 * RAND_PIXELS / 3) begin
                src_idle_pct = 65;
                snk_idle_pct = 22;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            if ($urandom_range(9) == 0) begin
                w = $urandom_range(13, 64);
                h = $urandom_range(1, 3);
            end else begin
                w = $urandom_range(1, 12);
                h = $urandom_range(1, 6);
            end
            if (src_idle_pct == 0 && !held_once) begin
                w = 8;
                h = 5;
            end
            if ($urandom_range(1)) begin
                write_reg(CFG_IMAGE_WIDTH, w);
                write_reg(CFG_IMAGE_HEIGHT, h);
            end else begin
                write_reg(CFG_IMAGE_HEIGHT, h);
                write_reg(CFG_IMAGE_WIDTH, w);
            end
            // whole images, sometimes cut short by the next restart
            n = w * h * $urandom_range(1, 2);
            if ($urandom_range(2) == 0) n += $urandom_range(0, w * h - 1);
            if (src_idle_pct == 0 && !held_once) begin
                @(posedge clk);
                hold_kick <= 1'b1;
                @(posedge clk);
                hold_kick <= 1'b0;
                held_once = 1'b1;
            end
            queue_random(n);
            rand_sent += n;
            wait_idle();
        end

        if (err_cnt == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

FILE: files.f
src/gem_pkg.sv
src/gem_pix_if.sv
src/gem_energy_if.sv
src/gem_ram.sv
src/gem_cell.sv
src/gradient_energy_map_core.sv
verif/tb.sv
